@@ design/lwbv_pkg.sv @@
// shared constants and types for the longest bounded-variation window unit
// no dependencies; imported by lwbv_diff_ram and longest_window_bounded_variation_unit
package lwbv_pkg;

	// default sizing
	localparam int MAX_WINDOW_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 32;

	// fixed field widths
	localparam int BUDGET_W = 48;
	localparam int LEN_W    = 11;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SHRINK
	} state_t;

endpackage

@@ design/longest_window_bounded_variation_unit.sv @@
// top level: sequencer, window bookkeeping, config register and output register
// depends on lwbv_pkg and lwbv_diff_ram
//
// Reports, for each signed sample, the longest run of consecutive samples ending there whose
// total variation (sum of absolute neighbor differences) is within variation_budget, plus the
// best such length in the sequence so far. Neighbor differences live in a circular store of
// MAX_WINDOW entries with a registered read. A sample is accepted while idle, its difference
// is pushed, differences are dropped from the window front until the sum fits, and the
// result is emitted; the first sample of a sequence has no push. The single read port of
// the difference store sets the drop rate at one per cycle. Each difference is dropped at
// most once. The next sample is taken while a finished word waits at the output; the unit
// stalls only when a second word is ready before the first is taken. After a word with last
// set, the sequence state returns to its reset value; the budget register keeps its value.
// No clearing pass is needed after reset. Write the budget only while the unit is idle.
module longest_window_bounded_variation_unit #(
	parameter int MAX_WINDOW  = lwbv_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = lwbv_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lwbv_pkg::BUDGET_W-1:0] variation_budget,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lwbv_pkg::LEN_W-1:0]    best_length,
	output logic [lwbv_pkg::LEN_W-1:0]    window_length,
	output logic                          done_res
);
	import lwbv_pkg::*;

	localparam int AW     = $clog2(MAX_WINDOW);
	localparam int CW     = $clog2(MAX_WINDOW + 1);
	localparam int LW     = $clog2(MAX_WINDOW + 2);
	localparam int DIFF_W = (SAMPLE_BITS > BUDGET_W) ? BUDGET_W + 1 : SAMPLE_BITS;
	localparam int EXT_W  = (SAMPLE_BITS > BUDGET_W + 1) ? SAMPLE_BITS : BUDGET_W + 1;
	localparam int SUM_W  = (AW + DIFF_W < BUDGET_W + 1) ? AW + DIFF_W : BUDGET_W + 1;
	localparam int CMP_W  = (SUM_W > BUDGET_W) ? SUM_W : BUDGET_W;
	localparam logic [EXT_W-1:0] CLAMP    = EXT_W'(1) << BUDGET_W;
	localparam logic [CW-1:0]    FULL_CNT = CW'(MAX_WINDOW);
	localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_WINDOW - 1);
	localparam logic [AW:0]      DEPTH_X  = (AW + 1)'(MAX_WINDOW);

	state_t state_q, state_d;

	logic [BUDGET_W-1:0]    budget_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic                   have_prev_q;
	logic [AW-1:0]          head_q, head_d;
	logic [CW-1:0]          count_q;
	logic [SUM_W-1:0]       sum_q;
	logic [LW-1:0]          best_q;
	logic [DIFF_W-1:0]      diff_q;
	logic                   last_q;

	logic                   out_valid_q;
	logic [LW-1:0]          best_out_q;
	logic [LW-1:0]          len_out_q;
	logic                   done_q;

	logic [SAMPLE_BITS-1:0] cur;
	logic [SAMPLE_BITS:0]   sub_cp, sub_pc;
	logic [SAMPLE_BITS-1:0] absd;
	logic [EXT_W-1:0]       absd_ext;
	logic [DIFF_W-1:0]      diff_new;

	logic                   in_fire, out_free, full, need_pop;
	logic                   do_push, do_pop, do_emit;
	logic [AW-1:0]          head_inc, tail, waddr;
	logic [AW:0]            tail_raw;
	logic [DIFF_W-1:0]      rdata;
	logic [SUM_W-1:0]       push_sum;
	logic [LW-1:0]          len_new, best_new;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_valid) begin
			budget_q <= variation_budget;
		end
	end

	// offset-binary sample and clamped absolute difference
	assign cur      = {~sample[SAMPLE_BITS-1], sample[SAMPLE_BITS-2:0]};
	assign sub_cp   = {1'b0, cur} - {1'b0, prev_q};
	assign sub_pc   = {1'b0, prev_q} - {1'b0, cur};
	assign absd     = sub_cp[SAMPLE_BITS] ? sub_pc[SAMPLE_BITS-1:0] : sub_cp[SAMPLE_BITS-1:0];
	assign absd_ext = EXT_W'(absd);
	assign diff_new = DIFF_W'((absd_ext > CLAMP) ? CLAMP : absd_ext);

	// handshake and window status
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign full     = (count_q == FULL_CNT);
	assign need_pop = (count_q != '0) && (CMP_W'(sum_q) > CMP_W'(budget_q));

	// circular indexes
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign tail_raw = (AW + 1)'(head_q) + (AW + 1)'(count_q);
	assign tail     = (tail_raw >= DEPTH_X) ? AW'(tail_raw - DEPTH_X) : tail_raw[AW-1:0];
	assign waddr    = full ? head_q : tail;

	// window sum after the push, dropping the oldest when full
	assign push_sum = full ? sum_q - SUM_W'(rdata) + SUM_W'(diff_q) : sum_q + SUM_W'(diff_q);

	// reported lengths
	assign len_new  = LW'(count_q) + LW'(1);
	assign best_new = (len_new > best_q) ? len_new : best_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = have_prev_q ? ST_PUSH : ST_SHRINK;
				end
			end
			ST_PUSH: begin
				state_d = ST_SHRINK;
			end
			ST_SHRINK: begin
				if (!need_pop && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_emit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_PUSH: begin
				do_push = 1'b1;
			end
			ST_SHRINK: begin
				do_pop  = need_pop;
				do_emit = !need_pop && out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// next head, also the read address so the oldest difference is ready in the next cycle
	always_comb begin
		head_d = head_q;
		if ((do_push && full) || do_pop) begin
			head_d = head_inc;
		end else if (do_emit && last_q) begin
			head_d = '0;
		end
	end

	lwbv_diff_ram #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW),
		.DW    (DIFF_W)
	) u_diff_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (waddr),
		.wdata (diff_q),
		.raddr (head_d),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// incoming word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			diff_q <= diff_new;
			last_q <= last;
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			head_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			best_q      <= LW'(1);
		end else begin
			head_q <= head_d;
			if (in_fire) begin
				prev_q      <= cur;
				have_prev_q <= 1'b1;
			end
			if (do_push) begin
				sum_q <= push_sum;
				if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (do_pop) begin
				sum_q   <= sum_q - SUM_W'(rdata);
				count_q <= count_q - CW'(1);
			end
			if (do_emit) begin
				if (last_q) begin
					prev_q      <= '0;
					have_prev_q <= 1'b0;
					count_q     <= '0;
					sum_q       <= '0;
					best_q      <= LW'(1);
				end else begin
					best_q <= best_new;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			best_out_q <= best_new;
			len_out_q  <= len_new;
			done_q     <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_length   = LEN_W'(best_out_q);
	assign window_length = LEN_W'(len_out_q);
	assign done_res      = done_q;

	// fill level never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("difference count above store depth");

	// an empty window carries no variation
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0))
		else $error("window sum nonzero with no differences");

	// a fresh sequence holds no differences
	a_fresh_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !have_prev_q) |-> (count_q == '0))
		else $error("differences left over from previous sequence");

	// best length covers the current window between samples
	a_best_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && have_prev_q) |-> (best_q > LW'(count_q)))
		else $error("best length below current window");

	// a drop never runs with the output register update
	a_pop_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> !$rose(out_valid_q) || $past(state_q) == ST_SHRINK)
		else $error("result issued while window still shrinking");

endmodule

@@ design/lwbv_diff_ram.sv @@
// difference store: one write port, one read port, registered read data
// a read of the entry written in the same cycle returns the new data
// depends on lwbv_pkg
module lwbv_diff_ram #(
	parameter int DEPTH = lwbv_pkg::MAX_WINDOW_DEF,
	parameter int AW    = $clog2(lwbv_pkg::MAX_WINDOW_DEF),
	parameter int DW    = lwbv_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	import lwbv_pkg::*;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port with write forwarding
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
